@@ sv/hbp_pkg.sv @@
// Shared constants and types for the Huffman bit packer.
`default_nettype none
package hbp_pkg;

    localparam int OP_W   = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 24;
    localparam int LEN_W  = 5;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SYM_W-1:0]  addr;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } tbl_req_t;

endpackage
`default_nettype wire

@@ sv/hbp_code_table.sv @@
// Code table: synchronous code/length memory plus per-entry valid bits.
`default_nettype none
module hbp_code_table #(
    parameter int MAX_CODE_LEN = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire hbp_pkg::tbl_req_t                    req,
    output logic                                      rsp_valid,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]         rsp_len,
    output logic [MAX_CODE_LEN-1:0]                   rsp_code
);

    localparam int TLEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int ENTRY_W = TLEN_W + MAX_CODE_LEN;
    localparam int DEPTH   = 1 << hbp_pkg::SYM_W;

    logic [ENTRY_W-1:0]      code_mem [DEPTH];
    logic [DEPTH-1:0]        valid_reg;
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    rd_valid_reg;

    logic [TLEN_W-1:0]       len_sat;
    logic [MAX_CODE_LEN-1:0] code_mask;

    always_comb begin
        if (req.len > hbp_pkg::LEN_W'(MAX_CODE_LEN)) begin
            len_sat = TLEN_W'(MAX_CODE_LEN);
        end else begin
            len_sat = TLEN_W'(req.len);
        end
        for (int i = 0; i < MAX_CODE_LEN; i++) begin
            code_mask[i] = (TLEN_W'(i) < len_sat);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            code_mem[req.addr] <= {len_sat, req.code[MAX_CODE_LEN-1:0] & code_mask};
        end
        if (req.rd_en) begin
            rd_data_reg <= code_mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rsp_valid = rd_valid_reg;
    assign rsp_len   = rd_data_reg[ENTRY_W-1:MAX_CODE_LEN];
    assign rsp_code  = rd_data_reg[MAX_CODE_LEN-1:0];

endmodule
`default_nettype wire

@@ sv/hbp_packer.sv @@
// Sequencer, bit window and output register of the bit packer.
`default_nettype none
module hbp_packer #(
    parameter int WINDOW_BITS  = 32,
    parameter int MAX_CODE_LEN = 24
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [hbp_pkg::OP_W-1:0]             in_op,
    input  wire logic [hbp_pkg::SYM_W-1:0]            in_sym,
    input  wire logic [hbp_pkg::CODE_W-1:0]           in_code,
    input  wire logic [hbp_pkg::LEN_W-1:0]            in_len,
    output hbp_pkg::tbl_req_t                         tbl_req,
    input  wire logic                                 rsp_valid,
    input  wire logic [$clog2(MAX_CODE_LEN+1)-1:0]    rsp_len,
    input  wire logic [MAX_CODE_LEN-1:0]              rsp_code,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [hbp_pkg::BYTE_W-1:0]                out_byte,
    output logic                                      out_last,
    output logic                                      out_err
);

    localparam int TLEN_W = $clog2(MAX_CODE_LEN + 1);
    localparam int HELD_W = $clog2(WINDOW_BITS + 1);
    localparam int SUM_W  = HELD_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic [WINDOW_BITS-1:0]      window_reg, window_next;
    logic [HELD_W-1:0]           held_reg, held_next;
    logic                        flush_reg, flush_next;
    logic                        miss_reg, miss_next;
    logic [TLEN_W-1:0]           len_reg, len_next;
    logic [MAX_CODE_LEN-1:0]     code_reg, code_next;
    logic                        out_valid_reg, out_valid_next;
    logic [hbp_pkg::BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_err_reg, out_err_next;

    logic                        accept;
    logic                        slot_free;
    logic [HELD_W-1:0]           held_dec;
    logic [WINDOW_BITS-1:0]      top_shift;
    logic [hbp_pkg::BYTE_W-1:0]  byte_top;
    logic [hbp_pkg::BYTE_W-1:0]  byte_pad;
    logic                        held_ge8;
    logic                        over;
    logic                        over_after;
    logic [WINDOW_BITS-1:0]      window_app;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb begin
        tbl_req.wr_en = accept && (in_op == hbp_pkg::OP_LOAD);
        tbl_req.rd_en = accept && (in_op == hbp_pkg::OP_ENCODE);
        tbl_req.addr  = in_sym;
        tbl_req.code  = in_code;
        tbl_req.len   = in_len;
    end

    assign held_dec   = held_reg - HELD_W'(8);
    assign held_ge8   = (held_reg >= HELD_W'(8));
    assign top_shift  = window_reg >> held_dec;
    assign byte_top   = top_shift[hbp_pkg::BYTE_W-1:0];
    assign byte_pad   = 8'(window_reg[7:0] << (4'd8 - {1'b0, held_reg[2:0]}));
    assign over       = (SUM_W'(held_reg) + SUM_W'(len_reg)) > SUM_W'(WINDOW_BITS);
    assign over_after = (SUM_W'(held_dec) + SUM_W'(len_reg)) > SUM_W'(WINDOW_BITS);
    assign window_app = (window_reg << len_reg) | WINDOW_BITS'(code_reg);

    always_comb begin
        state_next     = state_reg;
        window_next    = window_reg;
        held_next      = held_reg;
        flush_next     = flush_reg;
        miss_next      = miss_reg;
        len_next       = len_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        hbp_pkg::OP_ENCODE: begin
                            flush_next = 1'b0;
                            state_next = ST_LOOKUP;
                        end
                        hbp_pkg::OP_FLUSH: begin
                            if (held_reg != '0) begin
                                flush_next = 1'b1;
                                state_next = ST_EMIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                miss_next  = !rsp_valid;
                len_next   = rsp_len;
                code_next  = rsp_code;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (flush_reg) begin
                    if (slot_free) begin
                        out_valid_next = 1'b1;
                        out_err_next   = 1'b0;
                        out_byte_next  = held_ge8 ? byte_top : byte_pad;
                        held_next      = held_ge8 ? held_dec : '0;
                        out_last_next  = (held_reg <= HELD_W'(8));
                        if (held_reg <= HELD_W'(8)) begin
                            window_next = '0;
                            state_next  = ST_IDLE;
                        end
                    end
                end else if (miss_reg) begin
                    if (slot_free) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        out_last_next  = 1'b1;
                        out_err_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (over) begin
                    if (slot_free) begin
                        out_valid_next = 1'b1;
                        out_byte_next  = byte_top;
                        out_last_next  = !over_after;
                        out_err_next   = 1'b0;
                        held_next      = held_dec;
                    end
                end else begin
                    window_next = window_app;
                    held_next   = held_reg + HELD_W'(len_reg);
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            window_reg    <= '0;
            held_reg      <= '0;
            flush_reg     <= 1'b0;
            miss_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            held_reg      <= held_next;
            flush_reg     <= flush_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
        end
        len_reg      <= len_next;
        code_reg     <= code_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

endmodule
`default_nettype wire

@@ sv/huffman_bit_packer.sv @@
// Huffman bit packer: load an encode table, encode byte symbols into bytes, flush.
// Load, unused op, empty flush: complete on acceptance. Encode: accept, table read, output
// bytes (0 to 3 at 32-bit window), then append the code to the window.
// Unloaded symbol: accept, table read, one error transfer. Flush: accept, then the held bytes (up
// to 4). Bytes leave through an output register; a stalled output holds the sequencer.
// Reset (aresetn low, synchronous): all table entries invalid at once, window empty.
`default_nettype none
module huffman_bit_packer #(
    parameter int WINDOW_BITS  = 32,
    parameter int MAX_CODE_LEN = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // symbol[7:0], code_value[31:8], code_length[36:32]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte[7:0]
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // error[0]
);

    localparam int TLEN_W = $clog2(MAX_CODE_LEN + 1);

    hbp_pkg::tbl_req_t        tbl_req;
    logic                     rsp_valid;
    logic [TLEN_W-1:0]        rsp_len;
    logic [MAX_CODE_LEN-1:0]  rsp_code;
    logic                     out_err;

    hbp_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (tbl_req),
        .rsp_valid (rsp_valid),
        .rsp_len   (rsp_len),
        .rsp_code  (rsp_code)
    );

    hbp_packer #(
        .WINDOW_BITS  (WINDOW_BITS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_sym    (s_tdata[7:0]),
        .in_code   (s_tdata[31:8]),
        .in_len    (s_tdata[36:32]),
        .tbl_req   (tbl_req),
        .rsp_valid (rsp_valid),
        .rsp_len   (rsp_len),
        .rsp_code  (rsp_code),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_err   (out_err)
    );

    assign m_tuser[0] = out_err;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("error transfer without tlast");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 8'd0)
        else $error("error transfer with nonzero byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == hbp_pkg::OP_ENCODE |=> !s_tready)
        else $error("encode accepted without table lookup");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == hbp_pkg::OP_LOAD |=> !m_tvalid || $past(m_tvalid))
        else $error("load produced a transfer");
`endif

endmodule
`default_nettype wire
